// ===== hw/rtl/utf8cf_pkg.sv =====
// utf8cf_pkg: shared types and constants of the utf8 control character filter
// used by utf8cf_decode, utf8cf_out_fifo and utf8_control_char_filter_top
package utf8cf_pkg;

    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DEL       = 8'h7F;
    localparam logic [7:0] CHAR_HIGH      = 8'h80;

    localparam logic [7:0] MASK_LEAD2     = 8'hE0;
    localparam logic [7:0] CODE_LEAD2     = 8'hC0;
    localparam logic [7:0] MASK_LEAD3     = 8'hF0;
    localparam logic [7:0] CODE_LEAD3     = 8'hE0;
    localparam logic [7:0] MASK_LEAD4     = 8'hF8;
    localparam logic [7:0] CODE_LEAD4     = 8'hF0;
    localparam logic [1:0] CODE_CONT_TOP  = 2'b10;

    localparam logic [2:0] SEQ_LEN_NONE   = 3'd0;
    localparam logic [2:0] SEQ_LEN_2      = 3'd2;
    localparam logic [2:0] SEQ_LEN_3      = 3'd3;
    localparam logic [2:0] SEQ_LEN_4      = 3'd4;

    localparam int MAX_BURST   = 4;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       term;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [2:0]      num;
        logic            term;
        logic [3:0][7:0] data;
    } burst_t;

endpackage

// ===== hw/rtl/utf8cf_decode.sv =====
// utf8cf_decode: sequence state and byte classification, one request per cycle
// produces a burst of up to four results; depends on utf8cf_pkg
module utf8cf_decode
    import utf8cf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       string_end,
    output burst_t     burst
);

    logic [2:0][7:0] seq_buf_reg;
    logic [2:0][7:0] seq_buf_next;
    logic [1:0]      pend_cnt_reg;
    logic [1:0]      pend_cnt_next;
    logic [2:0]      seq_len_reg;
    logic [2:0]      seq_len_next;

    logic            pend_ok;
    logic            is_cont;
    logic [2:0]      pend_plus;

    always_comb
    begin
        pend_ok = (pend_cnt_reg != 2'd0) && (seq_len_reg >= SEQ_LEN_2)
                  && (seq_len_reg <= SEQ_LEN_4) && ({1'b0, pend_cnt_reg} < seq_len_reg);
        is_cont   = (data_byte[7:6] == CODE_CONT_TOP);
        pend_plus = {1'b0, pend_cnt_reg} + 3'd1;

        seq_buf_next  = seq_buf_reg;
        pend_cnt_next = pend_cnt_reg;
        seq_len_next  = seq_len_reg;
        burst.num     = 3'd0;
        burst.term    = 1'b0;
        burst.data[0] = data_byte;
        burst.data[1] = data_byte;
        burst.data[2] = data_byte;
        burst.data[3] = data_byte;

        if (accept)
        begin
            if (string_end)
            begin
                pend_cnt_next = 2'd0;
                seq_len_next  = SEQ_LEN_NONE;
                burst.num     = 3'd1;
                burst.term    = 1'b1;
                burst.data[0] = 8'h00;
            end
            else if (pend_ok && is_cont)
            begin
                if (pend_plus < seq_len_reg)
                begin
                    seq_buf_next[pend_cnt_reg] = data_byte;
                    pend_cnt_next              = pend_plus[1:0];
                end
                else
                begin
                    burst.num     = seq_len_reg;
                    burst.data[0] = seq_buf_reg[0];
                    burst.data[1] = (seq_len_reg == SEQ_LEN_2) ? data_byte : seq_buf_reg[1];
                    burst.data[2] = (seq_len_reg == SEQ_LEN_3) ? data_byte : seq_buf_reg[2];
                    burst.data[3] = data_byte;
                    pend_cnt_next = 2'd0;
                    seq_len_next  = SEQ_LEN_NONE;
                end
            end
            else
            begin
                pend_cnt_next = 2'd0;
                seq_len_next  = SEQ_LEN_NONE;
                if ((data_byte == CHAR_LF) || (data_byte == CHAR_TAB))
                begin
                    burst.num = 3'd1;
                end
                else if ((data_byte < CHAR_SPACE) || (data_byte == CHAR_DEL))
                begin
                    burst.num = 3'd0;
                end
                else if (data_byte < CHAR_HIGH)
                begin
                    burst.num = 3'd1;
                end
                else if ((data_byte & MASK_LEAD2) == CODE_LEAD2)
                begin
                    seq_len_next    = SEQ_LEN_2;
                    pend_cnt_next   = 2'd1;
                    seq_buf_next[0] = data_byte;
                end
                else if ((data_byte & MASK_LEAD3) == CODE_LEAD3)
                begin
                    seq_len_next    = SEQ_LEN_3;
                    pend_cnt_next   = 2'd1;
                    seq_buf_next[0] = data_byte;
                end
                else if ((data_byte & MASK_LEAD4) == CODE_LEAD4)
                begin
                    seq_len_next    = SEQ_LEN_4;
                    pend_cnt_next   = 2'd1;
                    seq_buf_next[0] = data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_buf_reg  <= '0;
            pend_cnt_reg <= 2'd0;
            seq_len_reg  <= SEQ_LEN_NONE;
        end
        else
        begin
            seq_buf_reg  <= seq_buf_next;
            pend_cnt_reg <= pend_cnt_next;
            seq_len_reg  <= seq_len_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pend_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg != 2'd0) |-> ((seq_len_reg >= SEQ_LEN_2) && (seq_len_reg <= SEQ_LEN_4)
                                    && ({1'b0, pend_cnt_reg} < seq_len_reg)))
        else $error("pending count out of step with sequence length");
    a_term_single: assert property (@(posedge clk) disable iff (!rst_n)
        burst.term |-> ((burst.num == 3'd1) && (burst.data[0] == 8'h00)))
        else $error("terminator burst malformed");
    a_idle_after_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (burst.num != 3'd0) |=> ((pend_cnt_reg == 2'd0) && (seq_len_reg == SEQ_LEN_NONE)))
        else $error("state not idle after emitting results");
    a_no_burst_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> (burst.num == 3'd0))
        else $error("results produced without a request");
`endif

endmodule

// ===== hw/rtl/utf8cf_out_fifo.sv =====
// utf8cf_out_fifo: result queue that takes a burst of up to four results per cycle
// and drains one per cycle while out_stall is low; depends on utf8cf_pkg
module utf8cf_out_fifo
    import utf8cf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  burst_t  burst,
    output logic    room,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_BURST));
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(burst.num);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(burst.num) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_BURST; k++)
        begin
            if (3'(k) < burst.num)
            begin
                mem_reg[wr_ptr_reg + FIFO_AW'(k)] <= '{data: burst.data[k],
                                                       term: burst.term,
                                                       last: (3'(k) + 3'd1 == burst.num)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (burst.num != 3'd0) |-> (count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_BURST)))
        else $error("burst written without room");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (burst.num == 3'd0)) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)))
        else $error("queue count wrong after pop");
`endif

endmodule

// ===== hw/rtl/utf8_control_char_filter_top.sv =====
// utf8_control_char_filter_top: text byte filter that drops control bytes and
// malformed utf8 lead sequences; depends on utf8cf_pkg, utf8cf_decode, utf8cf_out_fifo
//
// One input byte is taken per cycle and decided in the same cycle: printable
// ascii, newline and tab pass, other control bytes are dropped, and a utf8 lead
// byte with its continuation bytes is held until the sequence completes, at which
// point all of its bytes are released together. An end marker flushes any partial
// sequence and yields a single terminator result. Results leave through an
// eight-entry queue, one per cycle; in_stall rises while the queue holds more than
// four results, since a completed four-byte sequence writes four entries at once.
// With the output side never stalled the block sustains one input byte per cycle.
module utf8_control_char_filter_top
    import utf8cf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       string_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_terminator,
    output logic       last
);

    burst_t  burst;
    result_t head;
    logic    room;
    logic    accept;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    utf8cf_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .string_end (string_end),
        .burst      (burst)
    );

    utf8cf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .burst     (burst),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_byte      = head.data;
    assign is_terminator = head.term;
    assign last          = head.last;

endmodule
